FILE: design/kgsr_pkg.sv
// Shared constants and types for the k-group stream reverser.
package kgsr_pkg;

   localparam int MAX_GROUP = 64;
   localparam int WORD_W    = 32;
   localparam int ADDR_W    = $clog2(MAX_GROUP);
   localparam int CNT_W     = $clog2(MAX_GROUP + 1);
   localparam int GSIZE_W   = 7;

   typedef logic signed [WORD_W-1:0]  word_type;
   typedef logic        [ADDR_W-1:0]  addr_type;
   typedef logic        [CNT_W-1:0]   cnt_type;
   typedef logic        [GSIZE_W-1:0] gsize_type;

endpackage

FILE: design/kgsr_ifs.sv
// Channel interfaces of the k-group stream reverser: request, response, control register.
interface kgsr_req_if;
   logic                valid;
   logic                ready;
   kgsr_pkg::word_type  word;
   logic                end_of_list;

   modport source (output valid, output word, output end_of_list, input ready);
   modport sink   (input valid, input word, input end_of_list, output ready);
endinterface

interface kgsr_rsp_if;
   logic                valid;
   logic                ready;
   kgsr_pkg::word_type  out_word;
   logic                out_end;

   modport source (output valid, output out_word, output out_end, input ready);
   modport sink   (input valid, input out_word, input out_end, output ready);
endinterface

interface kgsr_csr_if;
   logic                valid;
   logic                ready;
   kgsr_pkg::gsize_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: design/k_group_stream_reverser_top.sv
// Top level of the k-group stream reverser: group buffer memory, drain sequencer, output stage.
//
// Usage:
//   req_if carries list words with an end-of-list mark; rsp_if returns the words with each
//   complete group of group_size reversed, a short tail in arrival order, and out_end on the
//   final word of every list. csr_if writes group_size (0 acts as 1, above 64 acts as 64);
//   it is always ready and must only be written while the block is idle.
//   Timing: a transaction that closes a group or ends the list starts a drain of n words: the
//   block takes no new request transaction while it reads the group memory, one address per
//   cycle while the output side is not stalled. The first word of the group reaches rsp_if
//   through the memory read register, then the output register; a complete group of n words
//   takes n - 1 transactions on the request side, then the closing one and its drain.
//   The single read port of the group memory sets this pace.
//   Reset (synchronous, active high) clears the fill count, the drain sequencer, the output
//   stages and sets group_size to 1. The memory is not cleared: only entries written for the
//   current group are ever read.
//   When the receiver stalls, the output register and the memory read register hold their
//   words and the drain pauses; nothing is lost or repeated.
module k_group_stream_reverser_top (
   input logic           clock,
   input logic           reset,
   kgsr_req_if.sink      req_if,
   kgsr_rsp_if.source    rsp_if,
   kgsr_csr_if.sink      csr_if
);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   // group buffer memory
   kgsr_pkg::word_type  mem [kgsr_pkg::MAX_GROUP];

   kgsr_pkg::gsize_type gsize_ff;
   kgsr_pkg::cnt_type   fill_ff, fill_in;
   logic                state_ff, state_in;
   kgsr_pkg::addr_type  addr_ff, addr_in;
   kgsr_pkg::cnt_type   cnt_ff, cnt_in;
   logic                rev_ff, rev_in;
   logic                last_ff, last_in;

   // memory read register stage
   kgsr_pkg::word_type  q_word_ff;
   logic                q_valid_ff, q_valid_in;
   logic                q_end_ff;

   // output register stage
   logic                out_valid_ff, out_valid_in;
   kgsr_pkg::word_type  out_word_ff;
   logic                out_end_ff;

   kgsr_pkg::cnt_type   eff_k;
   kgsr_pkg::cnt_type   n_words;
   logic                req_acc;
   logic                flush_rev;
   logic                flush_fwd;
   logic                out_free;
   logic                q_move;
   logic                rd_en;

   // Control register: always ready.
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gsize_ff <= kgsr_pkg::gsize_type'(1);
      end else if (csr_if.valid) begin
         gsize_ff <= csr_if.data;
      end
   end

   // Effective group size: zero acts as one, saturate at the buffer depth.
   always_comb begin
      if (gsize_ff == '0) begin
         eff_k = kgsr_pkg::cnt_type'(1);
      end else if (gsize_ff > kgsr_pkg::gsize_type'(kgsr_pkg::MAX_GROUP)) begin
         eff_k = kgsr_pkg::cnt_type'(kgsr_pkg::MAX_GROUP);
      end else begin
         eff_k = kgsr_pkg::cnt_type'(gsize_ff);
      end
   end

   // Take a request only between drains, so no pending read is overwritten.
   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_acc      = req_if.valid && req_if.ready;
   assign n_words      = fill_ff + kgsr_pkg::cnt_type'(1);
   assign flush_rev    = req_acc && (n_words >= eff_k);
   assign flush_fwd    = req_acc && !flush_rev && req_if.end_of_list;

   // Output pipeline handshake.
   assign out_free = !out_valid_ff || rsp_if.ready;
   assign q_move   = q_valid_ff && out_free;
   assign rd_en    = (state_ff == ST_DRAIN) && (!q_valid_ff || q_move);

   // Drain sequencer and fill count.
   always_comb begin
      fill_in  = fill_ff;
      state_in = state_ff;
      addr_in  = addr_ff;
      cnt_in   = cnt_ff;
      rev_in   = rev_ff;
      last_in  = last_ff;
      if (flush_rev || flush_fwd) begin
         fill_in  = '0;
         state_in = ST_DRAIN;
         cnt_in   = n_words;
         rev_in   = flush_rev;
         last_in  = req_if.end_of_list;
         addr_in  = flush_rev ? fill_ff[kgsr_pkg::ADDR_W-1:0] : '0;
      end else if (req_acc) begin
         fill_in = n_words;
      end
      if (rd_en) begin
         cnt_in  = cnt_ff - kgsr_pkg::cnt_type'(1);
         addr_in = rev_ff ? addr_ff - kgsr_pkg::addr_type'(1)
                          : addr_ff + kgsr_pkg::addr_type'(1);
         if (cnt_ff == kgsr_pkg::cnt_type'(1)) begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         fill_ff  <= fill_in;
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      rev_ff  <= rev_in;
      last_ff <= last_in;
   end

   // Memory: write on accept, registered read during drain (never in the same cycle).
   always_ff @(posedge clock) begin
      if (req_acc) begin
         mem[fill_ff[kgsr_pkg::ADDR_W-1:0]] <= req_if.word;
      end
      if (rd_en) begin
         q_word_ff <= mem[addr_ff];
      end
   end

   // Read stage: hold the word until the output register can take it.
   always_comb begin
      q_valid_in = q_valid_ff;
      if (rd_en) begin
         q_valid_in = 1'b1;
      end else if (q_move) begin
         q_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         q_end_ff <= last_ff && (cnt_ff == kgsr_pkg::cnt_type'(1));
      end
   end

   // Output stage: advance on free slot, drop valid once taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (q_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         q_valid_ff   <= q_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_move) begin
         out_word_ff <= q_word_ff;
         out_end_ff  <= q_end_ff;
      end
   end

   assign rsp_if.valid    = out_valid_ff;
   assign rsp_if.out_word = out_word_ff;
   assign rsp_if.out_end  = out_end_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff < kgsr_pkg::cnt_type'(kgsr_pkg::MAX_GROUP))
      else $error("fill count reached buffer depth between transactions");

   a_drain_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (cnt_ff != '0))
      else $error("drain active with no words left");

   a_read_lands: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> q_valid_ff)
      else $error("memory read did not land in read stage");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (q_valid_ff && out_valid_ff && !rsp_if.ready) |=> (q_valid_ff && $stable(q_word_ff)))
      else $error("read stage lost its word during output stall");
`endif

endmodule

FILE: tb/tb_k_group_stream_reverser_top.sv
// Self-checking testbench for the k-group stream reverser: directed and random lists.
`timescale 1ns / 1ps

module tb_k_group_stream_reverser_top;

   // Generous ceiling: the lists with random gaps, stalls and a long receiver
   // hold-off finish well before it.
   localparam int unsigned CYCLE_LIMIT  = 200000;
   // Cycles to let pass after the last expected word before a register write
   // or the end of the run (drain read + output register, plus slack).
   localparam int unsigned SETTLE_CYCLES = 12;
   localparam int unsigned MAX_REPORTS   = 10;

   // One expected word on the response channel.
   typedef struct packed {
      kgsr_pkg::word_type value;
      logic               last;
   } out_word_type;

   logic clock;
   logic reset;

   kgsr_req_if req_if ();
   kgsr_rsp_if rsp_if ();
   kgsr_csr_if csr_if ();

   k_group_stream_reverser_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // Clock: 10 ns period.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ------------------------------------------------------------------------
   // Reorder predictor: own copy of the group store, fill count and size
   // register. Each accepted request transaction pushes the words it releases
   // onto expected_words in the order the block must emit them.
   // ------------------------------------------------------------------------
   kgsr_pkg::word_type  grp_mem [kgsr_pkg::MAX_GROUP];
   int unsigned         grp_fill;
   kgsr_pkg::gsize_type grp_size;
   out_word_type        expected_words[$];

   // Size 0 behaves as 1, anything above the store depth as the store depth.
   function automatic int unsigned active_group_size();
      int unsigned k;
      k = 32'(grp_size);
      if (k == 0) k = 1;
      if (k > kgsr_pkg::MAX_GROUP) k = kgsr_pkg::MAX_GROUP;
      return k;
   endfunction

   function automatic void predict_reorder(kgsr_pkg::word_type w, logic eol);
      int unsigned  k;
      int unsigned  n;
      out_word_type item;
      k = active_group_size();
      if (grp_fill >= kgsr_pkg::MAX_GROUP) grp_fill = kgsr_pkg::MAX_GROUP - 1;
      grp_mem[grp_fill] = w;
      grp_fill++;
      n = grp_fill;
      if (n >= k) begin
         // Full group (or more, after the size was lowered): emit reversed.
         for (int unsigned i = 0; i < n; i++) begin
            item.value = grp_mem[n - 1 - i];
            item.last  = eol && (i == n - 1);
            expected_words.push_back(item);
         end
         grp_fill = 0;
      end else if (eol) begin
         // Short tail at end of list: emit in arrival order.
         for (int unsigned i = 0; i < n; i++) begin
            item.value = grp_mem[i];
            item.last  = (i == n - 1);
            expected_words.push_back(item);
         end
         grp_fill = 0;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Run control shared between the stimulus, the receiver and the checker.
   // ------------------------------------------------------------------------
   bit          idle_on;          // random gaps and stalls enabled
   int unsigned rsp_holdoff_req;  // long receiver hold-off, in cycles
   int unsigned rsp_stall_left;
   int unsigned fail_count;
   int unsigned cycle_count;

   // Watchdog: count cycles and end the run if it never drains.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("k_group_stream_reverser_top verification failed");
         $finish;
      end
   end

   // Receiver: drive ready at the falling edge. A hold-off request is picked up
   // and counted down here; otherwise stall now and then in random bursts.
   always @(negedge clock) begin
      if (rsp_holdoff_req != 0) begin
         rsp_stall_left  = rsp_holdoff_req;
         rsp_holdoff_req = 0;
      end
      if (rsp_stall_left != 0) begin
         rsp_if.ready <= 1'b0;
         rsp_stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_if.ready <= 1'b0;
         rsp_stall_left = $urandom_range(0, 5);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Checker: compare every accepted response transaction with the oldest
   // expectation, field by field. Keep going after a mismatch.
   always @(posedge clock) begin
      out_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_words.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("ERROR @%0t: unexpected word %h end=%b", $realtime,
                        rsp_if.out_word, rsp_if.out_end);
         end else begin
            want = expected_words.pop_front();
            if (rsp_if.out_word !== want.value || rsp_if.out_end !== want.last) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("ERROR @%0t: expected word %h end=%b, got word %h end=%b",
                           $realtime, want.value, want.last,
                           rsp_if.out_word, rsp_if.out_end);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Shared drivers
   // ------------------------------------------------------------------------

   // Offer one word; hold it until the block accepts the transaction, then
   // update the predictor. Returns just after the accepting edge, valid high.
   task automatic send_word(kgsr_pkg::word_type w, logic eol);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.word        <= w;
      req_if.end_of_list <= eol;
      do @(posedge clock); while (!req_if.ready);
      predict_reorder(w, eol);
   endtask

   // Drop valid, wait until every expected word is back, then let the
   // pipeline settle so the block is idle.
   task automatic wait_until_idle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write the group size; only called while the block is idle.
   task automatic write_group_size(kgsr_pkg::gsize_type size);
      wait_until_idle();
      csr_if.valid <= 1'b1;
      csr_if.data  <= size;
      do @(posedge clock); while (!csr_if.ready);
      grp_size = size;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Favor the extremes of the signed word range, otherwise any value.
   function automatic kgsr_pkg::word_type pick_word();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Send complete lists of random length and content, count words in all.
   task automatic send_random_lists(int unsigned count, int unsigned max_len);
      int unsigned sent;
      int unsigned len;
      sent = 0;
      while (sent < count) begin
         len = $urandom_range(1, max_len);
         if (len > count - sent) len = count - sent;
         for (int unsigned i = 0; i < len; i++)
            send_word(pick_word(), i == len - 1);
         sent += len;
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Size 1 out of reset: words pass straight through, end mark on the last.
   task automatic test_reset_passthrough();
      send_word(32'h8000_0000, 1'b0);
      send_word(32'h7FFF_FFFF, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b1);
   endtask

   // Size 3: two full groups plus a one-word tail, then a list whose end
   // mark lands exactly on a group boundary.
   task automatic test_groups_and_tail();
      write_group_size(7'd3);
      for (int unsigned i = 0; i < 7; i++)
         send_word(kgsr_pkg::word_type'(32'h1000_0000 + i), i == 6);
      for (int unsigned i = 0; i < 3; i++)
         send_word(kgsr_pkg::word_type'(32'hA5A5_0000 + i), i == 2);
   endtask

   // Lower the size while a partial group is buffered: the next word flushes
   // everything held, reversed. A lone end word then leaves on its own.
   task automatic test_size_lowered_mid_group();
      write_group_size(7'd6);
      for (int unsigned i = 0; i < 4; i++)
         send_word(kgsr_pkg::word_type'(32'h5A00_0000 + i), 1'b0);
      write_group_size(7'd2);
      send_word(32'h5A00_00FF, 1'b0);
      send_word(32'hDEAD_BEEF, 1'b1);
   endtask

   // Size 0 acts as 1.
   task automatic test_zero_size();
      write_group_size(7'd0);
      send_word(32'h0123_4567, 1'b0);
      send_word(32'hFEDC_BA98, 1'b1);
   endtask

   // Random lists over small, largest, saturating, zero and random sizes.
   task automatic test_random_sizes();
      kgsr_pkg::gsize_type size;
      size = kgsr_pkg::gsize_type'($urandom_range(2, 8));
      write_group_size(size);
      send_random_lists(60, 3 * size);
      write_group_size(kgsr_pkg::gsize_type'(kgsr_pkg::MAX_GROUP));
      send_random_lists(50, 2 * kgsr_pkg::MAX_GROUP);
      size = kgsr_pkg::gsize_type'($urandom_range(kgsr_pkg::MAX_GROUP + 1, 127));
      write_group_size(size);
      send_random_lists(40, 2 * kgsr_pkg::MAX_GROUP);
      write_group_size(7'd127);
      send_random_lists(20, kgsr_pkg::MAX_GROUP + 8);
      write_group_size(7'd0);
      send_random_lists(20, 4);
      size = kgsr_pkg::gsize_type'($urandom_range(1, kgsr_pkg::MAX_GROUP));
      write_group_size(size);
      send_random_lists(50, 2 * size + 1);
   endtask

   // Hold the receiver off for a long stretch while words keep coming, so
   // the block fills up and stalls its request side.
   task automatic test_backpressure();
      write_group_size(7'd8);
      rsp_holdoff_req = 300;
      send_random_lists(60, 24);
   endtask

   // Last part of the run: no gaps and no stalls on either side.
   task automatic test_full_rate();
      write_group_size(kgsr_pkg::gsize_type'($urandom_range(3, 12)));
      idle_on = 1'b0;
      send_random_lists(40, 30);
   endtask

   initial begin
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.word        = '0;
      req_if.end_of_list = 1'b0;
      rsp_if.ready       = 1'b0;
      csr_if.valid       = 1'b0;
      csr_if.data        = '0;
      idle_on            = 1'b1;
      rsp_holdoff_req    = 0;
      rsp_stall_left     = 0;
      fail_count         = 0;
      cycle_count        = 0;
      grp_fill           = 0;
      grp_size           = 7'd1;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_passthrough();
      test_groups_and_tail();
      test_size_lowered_mid_group();
      test_zero_size();
      test_random_sizes();
      test_backpressure();
      test_full_rate();

      wait_until_idle();
      if (fail_count == 0 && expected_words.size() == 0)
         $display("k_group_stream_reverser_top verification clean");
      else
         $display("k_group_stream_reverser_top verification failed");
      $finish;
   end

endmodule
